/* sv/cht_pkg.sv */
// shared types and constants for the chained hash table core
// no dependencies
package cht_pkg;

  localparam int MAX_BUCKETS = 128;
  localparam int POOL_NODES  = 256;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 8;
  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int DIV_W   = BKT_W + 1;
  localparam int IDX_W   = $clog2(POOL_NODES);
  localparam int PTR_W   = IDX_W + 1;
  localparam int STEP_W  = $clog2(KEY_W);

  localparam logic [CFG_W-1:0] BKT_CNT_RST = CFG_W'(127);
  localparam logic [PTR_W-1:0] NULL_PTR    = PTR_W'(POOL_NODES);
  localparam logic [PTR_W-1:0] POOL_FULL   = PTR_W'(POOL_NODES);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HEAD,
    ST_SEL,
    ST_INS,
    ST_RD,
    ST_CMP,
    ST_DONE
  } cht_state_t;

endpackage

/* sv/cht_mod.sv */
// bit-serial key modulo bucket count, one quotient bit per cycle
// depends on cht_pkg
module cht_mod
  import cht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [BKT_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [BKT_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    key_nxt  = key_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, key_r[KEY_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      key_nxt  = key;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      key_nxt = {key_r[KEY_W-2:0], 1'b0};
      if (trial >= div_r) begin
        rem_nxt = BKT_W'(trial - div_r);
      end else begin
        rem_nxt = BKT_W'(trial);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (DIV_W'(rem_r) < div_r))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("modulo unit restarted while busy");

endmodule

/* sv/chained_hash_table_core.sv */
// chained hash table core: one item at a time, input stalled from accept until the result
// is loaded; bucket from a bit-serial modulo, chain walked per node in a read then a compare
// state; the next input is accepted at the earliest in the cycle the result is presented;
// a stalled result beat holds the core, and a pending configuration beat holds off the input;
// registered memory reads
// reset (rst_n, synchronous): all buckets empty, pool empty, bucket count 127
module chained_hash_table_core
  import cht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_entry_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [DATA_W-1:0] out_result_data,
  output logic              out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_bucket_count
);

  cht_state_t        state_r, state_nxt;
  logic              mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] data_r;
  logic [BKT_W-1:0]  bucket_r, bucket_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic              res_found_r, res_found_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic              res_status_r, res_status_nxt;
  logic [PTR_W-1:0]  nodes_used_r, nodes_used_nxt;
  logic [CFG_W-1:0]  bucket_count_r;
  logic [MAX_BUCKETS-1:0] head_vld_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_status_r;

  logic [PTR_W-1:0]  head_mem [MAX_BUCKETS];
  logic [KEY_W-1:0]  node_key_mem [POOL_NODES];
  logic [DATA_W-1:0] node_val_mem [POOL_NODES];
  logic [PTR_W-1:0]  node_link_mem [POOL_NODES];

  logic [PTR_W-1:0]  head_q_r;
  logic [KEY_W-1:0]  node_key_q_r;
  logic [DATA_W-1:0] node_val_q_r;
  logic [PTR_W-1:0]  node_link_q_r;

  logic              in_beat, cfg_beat, out_load, ins_we;
  logic              mod_start, mod_done;
  logic [BKT_W-1:0]  mod_rem;
  logic [DIV_W-1:0]  div_eff;
  logic [PTR_W-1:0]  head_eff;

  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_beat  = cfg_valid && cfg_ready;

  always_comb begin
    if (bucket_count_r == '0) begin
      div_eff = DIV_W'(1);
    end else if (DIV_W'(bucket_count_r) > DIV_W'(MAX_BUCKETS)) begin
      div_eff = DIV_W'(MAX_BUCKETS);
    end else begin
      div_eff = DIV_W'(bucket_count_r);
    end
  end

  assign head_eff = head_vld_r[bucket_r] ? head_q_r : NULL_PTR;

  cht_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .key     (in_key),
    .divisor (div_eff),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    bucket_nxt     = bucket_r;
    cur_nxt        = cur_r;
    res_found_nxt  = res_found_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    nodes_used_nxt = nodes_used_r;
    mod_start      = 1'b0;
    ins_we         = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          mod_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          bucket_nxt = mod_rem;
          state_nxt  = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        res_found_nxt  = 1'b0;
        res_data_nxt   = '0;
        res_status_nxt = STATUS_OK;
        cur_nxt        = head_eff;
        state_nxt      = (mode_r == MODE_INSERT) ? ST_INS : ST_RD;
      end
      ST_INS: begin
        if (nodes_used_r == POOL_FULL) begin
          res_status_nxt = STATUS_FULL;
        end else begin
          ins_we         = 1'b1;
          nodes_used_nxt = nodes_used_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_RD: begin
        state_nxt = (cur_r == NULL_PTR) ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        if (node_key_q_r == key_r) begin
          res_found_nxt = 1'b1;
          res_data_nxt  = node_val_q_r;
          state_nxt     = ST_DONE;
        end else begin
          cur_nxt   = node_link_q_r;
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      nodes_used_r   <= '0;
      bucket_count_r <= BKT_CNT_RST;
      head_vld_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_beat) begin
        bucket_count_r <= cfg_bucket_count;
      end
      if (ins_we) begin
        head_vld_r[bucket_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      data_r <= in_entry_data;
    end
    bucket_r     <= bucket_nxt;
    cur_r        <= cur_nxt;
    res_found_r  <= res_found_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (ins_we) begin
      head_mem[bucket_r] <= nodes_used_r;
    end
    head_q_r <= head_mem[bucket_r];
  end

  // node pool memories
  always_ff @(posedge clk) begin
    if (ins_we) begin
      node_key_mem[nodes_used_r[IDX_W-1:0]]  <= key_r;
      node_val_mem[nodes_used_r[IDX_W-1:0]]  <= data_r;
      node_link_mem[nodes_used_r[IDX_W-1:0]] <= head_eff;
    end
    node_key_q_r  <= node_key_mem[cur_r[IDX_W-1:0]];
    node_val_q_r  <= node_val_mem[cur_r[IDX_W-1:0]];
    node_link_q_r <= node_link_mem[cur_r[IDX_W-1:0]];
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_result_data = out_data_r;
  assign out_status      = out_status_r;

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= POOL_FULL)
    else $error("node count beyond pool size");

  a_walk_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD && cur_r != NULL_PTR) |-> (cur_r < nodes_used_r))
    else $error("chain walk reached an unwritten node");

  a_found_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_status_r))
    else $error("result both found and pool full");

  a_count_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && nodes_used_r != $past(nodes_used_r)) |->
      ($past(state_r) == ST_INS))
    else $error("node count moved outside insert");

endmodule

/* tb/sv/chained_hash_table_core_tb.sv */
// testbench for chained_hash_table_core: directed table then random insert/lookup traffic
// every result beat checked vs row reply or in-bench hash table predictor; needs cht_pkg
module chained_hash_table_core_tb;
  import cht_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_WAIT       = 600;
  localparam int N_DIRECTED     = 20;
  localparam int N_SWEEP        = 12;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] data;
    logic              status;
  } table_reply_t;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic              chk;
    table_reply_t      want;
  } directed_row_t;

  // keys 0, 7f, fe map to bucket 0; ffffffff lands in 15, 80000000 in 8, 7fffffff in 7
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    {MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
    {MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, STATUS_OK},
    {MODE_INSERT, 32'h0000_007F, 32'h1111_1111, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
    {MODE_LOOKUP, 32'h0000_007F, 32'h0000_0000, 1'b1, 1'b1, 32'h1111_1111, STATUS_OK},
    {MODE_LOOKUP, 32'h0000_00FE, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_INSERT, 32'h0000_0000, 32'h2222_2222, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h2222_2222, STATUS_OK},
    {MODE_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A, STATUS_OK},
    {MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5, STATUS_OK},
    {MODE_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, STATUS_OK},
    {MODE_LOOKUP, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, STATUS_OK}
  };

  localparam logic [CFG_W-1:0] BKT_SWEEP [N_SWEEP] = '{
    8'd128, 8'd1, 8'd255, 8'd64, 8'd0, 8'd129, 8'd7, 8'd127, 8'd200, 8'd2, 8'd1, 8'd100
  };

  localparam logic [KEY_W-1:0] KEY_CORNERS [4] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
  };

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic              in_mode          = MODE_LOOKUP;
  logic [KEY_W-1:0]  in_key           = '0;
  logic [DATA_W-1:0] in_entry_data    = '0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic              out_found;
  logic [DATA_W-1:0] out_result_data;
  logic              out_status;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_bucket_count = BKT_CNT_RST;

  // typed expectation riding along with the input beat
  logic              row_chk          = 1'b0;
  table_reply_t      row_want         = '0;

  int                in_idle_pct      = 12;
  int                out_idle_pct     = 65;
  int                items_sent       = 0;
  int                results_seen     = 0;
  int                mismatches       = 0;
  int                quiet_cycles     = 0;

  table_reply_t      table_replies[$];

  // predictor state
  logic [PTR_W-1:0]  p_heads [MAX_BUCKETS];
  logic [KEY_W-1:0]  p_keys  [POOL_NODES];
  logic [DATA_W-1:0] p_vals  [POOL_NODES];
  logic [PTR_W-1:0]  p_links [POOL_NODES];
  int unsigned       p_used;
  logic [CFG_W-1:0]  p_bkt_cnt;

  chained_hash_table_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_key           (in_key),
    .in_entry_data    (in_entry_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_result_data  (out_result_data),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bucket_count (cfg_bucket_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic int unsigned used_buckets(logic [CFG_W-1:0] cnt);
    int unsigned n;
    n = cnt;
    if (n == 0) n = 1;
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    return n;
  endfunction

  function automatic table_reply_t table_step(logic mode, logic [KEY_W-1:0] key,
                                              logic [DATA_W-1:0] data);
    table_reply_t     r;
    int unsigned      b;
    int unsigned      steps;
    logic [PTR_W-1:0] cur;
    r = '0;
    b = key % used_buckets(p_bkt_cnt);
    if (mode == MODE_INSERT) begin
      if (p_used >= POOL_NODES) begin
        r.status = STATUS_FULL;
      end else begin
        p_keys[p_used]  = key;
        p_vals[p_used]  = data;
        p_links[p_used] = p_heads[b];
        p_heads[b]      = PTR_W'(p_used);
        p_used++;
      end
    end else begin
      cur   = p_heads[b];
      steps = 0;
      while (cur != NULL_PTR && steps < POOL_NODES) begin
        if (p_keys[cur[IDX_W-1:0]] == key) begin
          r.found = 1'b1;
          r.data  = p_vals[cur[IDX_W-1:0]];
          break;
        end
        cur = p_links[cur[IDX_W-1:0]];
        steps++;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %h got %h (result %0d)", what, want, got, results_seen);
  endtask

  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    logic         moved;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BUCKETS; i++) p_heads[i] = NULL_PTR;
      p_used       = 0;
      p_bkt_cnt    = BKT_CNT_RST;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got   = {out_found, out_result_data, out_status};
        results_seen++;
        if (table_replies.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, out_result_data);
        end else begin
          want = table_replies.pop_front();
          if (got.found != want.found) flag_mismatch("found", want.found, got.found);
          if (got.data != want.data) flag_mismatch("result_data", want.data, got.data);
          if (got.status != want.status) flag_mismatch("status", want.status, got.status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved     = 1'b1;
        p_bkt_cnt = cfg_bucket_count;
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want  = table_step(in_mode, in_key, in_entry_data);
        table_replies.push_back(row_chk ? row_want : want);
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_op(logic mode, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data,
                         logic chk, table_reply_t want);
    if (items_sent < 570) begin
      in_idle_pct  = 12;
      out_idle_pct = 65;
    end else if (items_sent < 1120) begin
      in_idle_pct  = 65;
      out_idle_pct = 12;
    end else begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_key        <= key;
    in_entry_data <= data;
    row_chk       <= chk;
    row_want      <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [CFG_W-1:0] cnt);
    cfg_valid        <= 1'b1;
    cfg_bucket_count <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] known_keys[$];
    logic [KEY_W-1:0] key;
    logic             mode;
    int unsigned      eff;
    int               sel;
    int               n_items;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the bucket count is in force here
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_op(DIRECTED[i].mode, DIRECTED[i].key, DIRECTED[i].data,
              DIRECTED[i].chk, DIRECTED[i].want);
      if (DIRECTED[i].mode == MODE_INSERT) known_keys.push_back(DIRECTED[i].key);
    end

    for (int ph = 0; ph < N_SWEEP; ph++) begin
      drain();
      write_bucket_count(BKT_SWEEP[ph]);
      eff     = used_buckets(BKT_SWEEP[ph]);
      n_items = (eff <= 2) ? 40 : 184;
      for (int i = 0; i < n_items; i++) begin
        mode = ($urandom_range(99) < 30) ? MODE_INSERT : MODE_LOOKUP;
        sel  = $urandom_range(99);
        if (sel < 35 && known_keys.size() > 0)
          key = known_keys[$urandom_range(known_keys.size() - 1)];
        else if (sel < 55)
          key = KEY_W'(eff * $urandom_range(0, 2000) + $urandom_range(0, 2));
        else if (sel < 65)
          key = KEY_CORNERS[$urandom_range(3)];
        else
          key = $urandom;
        if (mode == MODE_INSERT) begin
          known_keys.push_back(key);
          if (known_keys.size() > 512) void'(known_keys.pop_front());
        end
        send_op(mode, key, $urandom, 1'b0, '0);
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && table_replies.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* chained_hash_table_core.f */
sv/cht_pkg.sv
sv/cht_mod.sv
sv/chained_hash_table_core.sv
tb/sv/chained_hash_table_core_tb.sv
